FILE: rtl/core/mandel_pkg.sv
// ----------------------------------------------------------------------------
// mandel_pkg
// shared types and constants of the escape-time pixel engine
// ----------------------------------------------------------------------------
package mandel_pkg;

  // field widths
  localparam int unsigned COORD_W = 12;
  localparam int unsigned ITER_W  = 12;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned CFG_W   = 12;

  // integer bits kept above the binary point, sign included
  localparam int unsigned INT_BITS = 12;
  // extra headroom of a square over an operand
  localparam int unsigned SQ_EXTRA = 12;
  // digit width of the shared multiplier
  localparam int unsigned MUL_DIGIT_W = 16;

  // register reset values
  localparam logic [COLOR_W-1:0] EXT_COLOR_RST = 8'd255;
  localparam logic [ITER_W-1:0]  ITER_LIMIT_RST = 12'd200;

  typedef enum logic [1:0] {
    CFG_EXT_RED    = 2'd0,
    CFG_EXT_GREEN  = 2'd1,
    CFG_EXT_BLUE   = 2'd2,
    CFG_ITER_LIMIT = 2'd3
  } cfg_index_e;

  typedef enum logic [3:0] {
    CTRL_IDLE,
    CTRL_MAP_X,
    CTRL_MAP_Y,
    CTRL_SNAP,
    CTRL_TEST,
    CTRL_MUL_XY,
    CTRL_UPDATE,
    CTRL_SQ_X,
    CTRL_MUL_XX,
    CTRL_MUL_YY,
    CTRL_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_RUN,
    MUL_FIN
  } mul_state_e;

  // request to the shared multiplier
  typedef struct packed {
    logic start;
    logic dbl;
  } mul_ctrl_t;

endpackage

FILE: rtl/core/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// maps a pixel onto the complex plane and counts escape-time iterations
// each iteration runs three products on the shared multiplier, which works
//   through D = ceil((FRACTION_BITS + 12) / 16) digits of its b operand
// throughput: one pixel at a time, next input taken after the result transfer
// reset: asynchronous, returns to idle, colours 255, iteration limit 200
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
  parameter int unsigned IMAGE_SIZE    = 800,
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [mandel_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mandel_pkg::COORD_W-1:0]      column_i,
  input  logic [mandel_pkg::COORD_W-1:0]      row_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mandel_pkg::ITER_W-1:0]       iterations_o,
  output logic                                inside_res_o,
  output logic [mandel_pkg::COLOR_W-1:0]      red_o,
  output logic [mandel_pkg::COLOR_W-1:0]      green_o,
  output logic [mandel_pkg::COLOR_W-1:0]      blue_o
);

  localparam int unsigned W  = FRACTION_BITS + mandel_pkg::INT_BITS;
  localparam int unsigned SW = W + mandel_pkg::SQ_EXTRA;
  localparam int unsigned CRD_W = mandel_pkg::COORD_W;
  localparam int unsigned IT_W  = mandel_pkg::ITER_W;
  localparam int unsigned COL_W = mandel_pkg::COLOR_W;

  localparam logic [63:0]       STEP_WIDE = (64'd4 << FRACTION_BITS) / 64'(IMAGE_SIZE);
  localparam logic [W-1:0]      STEP_U    = W'(STEP_WIDE);
  localparam logic signed [W:0] STEP1     = (W+1)'(STEP_WIDE);
  localparam logic signed [W:0] NEG_STEP1 = -STEP1;
  localparam logic signed [W-1:0] CX_MIN  = -(W'(5) << (FRACTION_BITS - 1));
  localparam logic signed [W-1:0] CY_MIN  = -(W'(2) << FRACTION_BITS);
  localparam logic signed [SW:0]  ESCAPE  = (SW+1)'(4) << FRACTION_BITS;

  mandel_pkg::ctrl_state_e state_q, state_d;

  // configuration
  logic [COL_W-1:0] ext_red_q, ext_green_q, ext_blue_q;
  logic [IT_W-1:0]  limit_q;

  // working registers
  logic [CRD_W-1:0]     col_q, row_q;
  logic signed [W-1:0]  cx_q, cy_q, zx_q, zy_q;
  logic signed [SW-1:0] zx2_q, zy2_q;
  logic [IT_W-1:0]      n_q;
  logic                 inside_q;

  // multiplier
  mandel_pkg::mul_ctrl_t mul_ctrl;
  logic signed [W-1:0]   mul_a, mul_b;
  logic                  mul_done;
  logic signed [SW-1:0]  mul_res;

  logic [CRD_W-1:0]     map_sel;
  logic [W-1:0]         map_prod;
  logic signed [W-1:0]  map_val;
  logic signed [W:0]    two_cy;
  logic                 snap;
  logic signed [SW:0]   mag_sum;
  logic                 go_on;
  logic signed [SW-1:0] zx_diff;
  logic signed [W-1:0]  zy_new, zx_new;
  logic                 load_px;

  assign map_sel  = (state_q == mandel_pkg::CTRL_MAP_X) ? col_q : row_q;
  assign map_prod = W'(map_sel) * STEP_U;
  assign map_val  = $signed(map_prod)
                    + ((state_q == mandel_pkg::CTRL_MAP_X) ? CX_MIN : CY_MIN);

  // points within half a step of the real axis sit on it
  assign two_cy = {cy_q, 1'b0};
  assign snap   = (two_cy > NEG_STEP1) && (two_cy < STEP1);

  assign mag_sum = (SW+1)'(zx2_q) + (SW+1)'(zy2_q);
  assign go_on   = (n_q < limit_q) && (mag_sum < ESCAPE);

  assign zx_diff = zx2_q - zy2_q;
  assign zy_new  = $signed(mul_res[W-1:0]) + cy_q;
  assign zx_new  = $signed(zx_diff[W-1:0]) + cx_q;

  mandel_mul #(
    .OP_W      (W),
    .RES_W     (SW),
    .FRAC_BITS (FRACTION_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mandel_pkg::CTRL_IDLE: begin
        if (in_valid_i) state_d = mandel_pkg::CTRL_MAP_X;
      end
      mandel_pkg::CTRL_MAP_X: state_d = mandel_pkg::CTRL_MAP_Y;
      mandel_pkg::CTRL_MAP_Y: state_d = mandel_pkg::CTRL_SNAP;
      mandel_pkg::CTRL_SNAP:  state_d = mandel_pkg::CTRL_TEST;
      mandel_pkg::CTRL_TEST: begin
        state_d = go_on ? mandel_pkg::CTRL_MUL_XY : mandel_pkg::CTRL_OUT;
      end
      mandel_pkg::CTRL_MUL_XY: begin
        if (mul_done) state_d = mandel_pkg::CTRL_UPDATE;
      end
      mandel_pkg::CTRL_UPDATE: state_d = mandel_pkg::CTRL_SQ_X;
      mandel_pkg::CTRL_SQ_X:   state_d = mandel_pkg::CTRL_MUL_XX;
      mandel_pkg::CTRL_MUL_XX: begin
        if (mul_done) state_d = mandel_pkg::CTRL_MUL_YY;
      end
      mandel_pkg::CTRL_MUL_YY: begin
        if (mul_done) state_d = mandel_pkg::CTRL_TEST;
      end
      mandel_pkg::CTRL_OUT: begin
        if (out_ready_i) state_d = mandel_pkg::CTRL_IDLE;
      end
      default: state_d = mandel_pkg::CTRL_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    mul_ctrl.start = 1'b0;
    mul_ctrl.dbl   = 1'b0;
    mul_a          = zx_q;
    mul_b          = zy_q;
    unique case (state_q)
      mandel_pkg::CTRL_IDLE: in_ready_o = 1'b1;
      mandel_pkg::CTRL_TEST: begin
        mul_ctrl.start = go_on;
        mul_ctrl.dbl   = 1'b1;
      end
      mandel_pkg::CTRL_SQ_X: begin
        mul_ctrl.start = 1'b1;
        mul_b          = zx_q;
      end
      mandel_pkg::CTRL_MUL_XX: begin
        mul_ctrl.start = mul_done;
        mul_a          = zy_q;
      end
      mandel_pkg::CTRL_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign load_px = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mandel_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_red_q   <= mandel_pkg::EXT_COLOR_RST;
      ext_green_q <= mandel_pkg::EXT_COLOR_RST;
      ext_blue_q  <= mandel_pkg::EXT_COLOR_RST;
      limit_q     <= mandel_pkg::ITER_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (mandel_pkg::cfg_index_e'(cfg_index_i))
        mandel_pkg::CFG_EXT_RED:    ext_red_q   <= cfg_data_i[COL_W-1:0];
        mandel_pkg::CFG_EXT_GREEN:  ext_green_q <= cfg_data_i[COL_W-1:0];
        mandel_pkg::CFG_EXT_BLUE:   ext_blue_q  <= cfg_data_i[COL_W-1:0];
        mandel_pkg::CFG_ITER_LIMIT: limit_q     <= cfg_data_i[IT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_px) begin
      col_q <= column_i;
      row_q <= row_i;
    end
    unique case (state_q)
      mandel_pkg::CTRL_MAP_X: cx_q <= map_val;
      mandel_pkg::CTRL_MAP_Y: cy_q <= map_val;
      mandel_pkg::CTRL_SNAP: begin
        if (snap) cy_q <= '0;
        zx_q  <= '0;
        zy_q  <= '0;
        zx2_q <= '0;
        zy2_q <= '0;
        n_q   <= '0;
      end
      mandel_pkg::CTRL_TEST: begin
        inside_q <= (n_q == limit_q);
      end
      mandel_pkg::CTRL_UPDATE: begin
        zy_q <= zy_new;
        zx_q <= zx_new;
      end
      mandel_pkg::CTRL_MUL_XX: begin
        if (mul_done) zx2_q <= mul_res;
      end
      mandel_pkg::CTRL_MUL_YY: begin
        if (mul_done) begin
          zy2_q <= mul_res;
          n_q   <= n_q + IT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign iterations_o = n_q;
  assign inside_res_o = inside_q;
  assign red_o        = inside_q ? '0 : ext_red_q;
  assign green_o      = inside_q ? '0 : ext_green_q;
  assign blue_o       = inside_q ? '0 : ext_blue_q;

endmodule

FILE: rtl/core/mandel_mul.sv
// ----------------------------------------------------------------------------
// mandel_mul
// shared fixed-point multiplier, one 16-bit digit of b per cycle,
// result floor(a*b / 2^frac) or floor(2*a*b / 2^frac)
// ----------------------------------------------------------------------------
module mandel_mul #(
  parameter int unsigned OP_W      = 40,
  parameter int unsigned RES_W     = 52,
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mandel_pkg::mul_ctrl_t   ctrl_i,
  input  logic signed [OP_W-1:0]  op_a_i,
  input  logic signed [OP_W-1:0]  op_b_i,
  output logic                    done_o,
  output logic signed [RES_W-1:0] res_o
);

  localparam int unsigned DIGIT = mandel_pkg::MUL_DIGIT_W;
  localparam int unsigned NCH   = (OP_W + DIGIT - 1) / DIGIT;
  localparam int unsigned BW    = NCH * DIGIT;
  localparam int unsigned PW    = OP_W + BW;
  localparam int unsigned CW    = (NCH > 1) ? $clog2(NCH) : 1;

  mandel_pkg::mul_state_e state_q, state_d;

  logic [OP_W-1:0]         mag_a_q;
  logic [BW-1:0]           b_q;
  logic [PW-1:0]           acc_q;
  logic                    neg_q;
  logic                    dbl_q;
  logic [CW-1:0]           cnt_q;
  logic signed [RES_W-1:0] res_q;
  logic                    done_q;

  logic                    load;
  logic                    step;
  logic                    finish;

  logic [OP_W-1:0]         a_u;
  logic [OP_W-1:0]         b_u;
  logic [OP_W-1:0]         mag_a;
  logic [OP_W-1:0]         mag_b;
  logic [OP_W+DIGIT-1:0]   partial;
  logic [PW-1:0]           acc_next;
  logic signed [PW:0]      full;
  logic signed [PW:0]      shifted;

  assign a_u   = op_a_i;
  assign b_u   = op_b_i;
  assign mag_a = a_u[OP_W-1] ? (~a_u + OP_W'(1)) : a_u;
  assign mag_b = b_u[OP_W-1] ? (~b_u + OP_W'(1)) : b_u;

  assign partial  = (OP_W+DIGIT)'(mag_a_q) * (OP_W+DIGIT)'(b_q[BW-1 -: DIGIT]);
  assign acc_next = {acc_q[PW-DIGIT-1:0], {DIGIT{1'b0}}} + PW'(partial);

  assign full    = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
  assign shifted = dbl_q ? (full >>> (FRAC_BITS - 1)) : (full >>> FRAC_BITS);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mandel_pkg::MUL_IDLE: begin
        if (ctrl_i.start) state_d = mandel_pkg::MUL_RUN;
      end
      mandel_pkg::MUL_RUN: begin
        if (cnt_q == CW'(NCH - 1)) state_d = mandel_pkg::MUL_FIN;
      end
      mandel_pkg::MUL_FIN: begin
        state_d = mandel_pkg::MUL_IDLE;
      end
      default: state_d = mandel_pkg::MUL_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    load   = 1'b0;
    step   = 1'b0;
    finish = 1'b0;
    unique case (state_q)
      mandel_pkg::MUL_IDLE: load   = ctrl_i.start;
      mandel_pkg::MUL_RUN:  step   = 1'b1;
      mandel_pkg::MUL_FIN:  finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mandel_pkg::MUL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mag_a_q <= mag_a;
      b_q     <= BW'(mag_b);
      acc_q   <= '0;
      neg_q   <= a_u[OP_W-1] ^ b_u[OP_W-1];
      dbl_q   <= ctrl_i.dbl;
      cnt_q   <= '0;
    end else if (step) begin
      acc_q <= acc_next;
      b_q   <= b_q << DIGIT;
      cnt_q <= cnt_q + CW'(1);
    end
    if (finish) begin
      res_q <= shifted[RES_W-1:0];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: rtl/core/mandel_checker.sv
// ----------------------------------------------------------------------------
// mandel_checker
// port-level checks of the escape-time pixel engine
// ----------------------------------------------------------------------------
module mandel_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [mandel_pkg::ITER_W-1:0]  iterations_o,
  input logic                           inside_res_o,
  input logic [mandel_pkg::COLOR_W-1:0] red_o,
  input logic [mandel_pkg::COLOR_W-1:0] green_o,
  input logic [mandel_pkg::COLOR_W-1:0] blue_o
);

  // one pixel in flight: no input while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // an input transfer closes the input side
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready after a transfer");

  // pixels in the set are black
  a_inside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_res_o) |-> (red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("inside pixel not black");

  // escape needs at least one iteration
  a_escape_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !inside_res_o) |-> (iterations_o != '0))
    else $error("escaped pixel with zero iterations");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(iterations_o)))
    else $error("result changed while stalled");

endmodule

bind mandelbrot_escape_time_pixel mandel_checker u_mandel_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .iterations_o (iterations_o),
  .inside_res_o (inside_res_o),
  .red_o        (red_o),
  .green_o      (green_o),
  .blue_o       (blue_o)
);

FILE: verif/mandelbrot_escape_time_pixel_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_test
// Self-checking bench for the escape-time pixel engine. Pixel coordinates are
// fed through a valid/ready driver and every result transfer is checked field
// by field against a fixed-point predictor of the escape loop kept in the
// bench. Colour and iteration-limit registers change between phases.
// The run covers edge coordinates, the axis snap, the zero limit and
// off-image pixels. Random pixels follow in phases, most with random sender and
// receiver gaps, and two long receiver hold-offs.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_test;

  localparam int unsigned IMAGE_SIZE    = 800;
  localparam int unsigned FRACTION_BITS = 28;

  localparam longint PLANE_STEP = (longint'(4) << FRACTION_BITS) / IMAGE_SIZE;
  localparam longint CX_ORIGIN  = -(longint'(5) << (FRACTION_BITS - 1));
  localparam longint CY_ORIGIN  = -(longint'(2) << FRACTION_BITS);
  localparam longint ESCAPE_R2  = longint'(4) << FRACTION_BITS;

  localparam int unsigned CYCLE_LIMIT  = 6000000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE_WAIT  = 200;
  localparam int unsigned NUM_PHASES   = 7;

  typedef struct packed {
    logic [mandel_pkg::COORD_W-1:0] column;
    logic [mandel_pkg::COORD_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [mandel_pkg::ITER_W-1:0]  iterations;
    logic                           in_set;
    logic [mandel_pkg::COLOR_W-1:0] red;
    logic [mandel_pkg::COLOR_W-1:0] green;
    logic [mandel_pkg::COLOR_W-1:0] blue;
  } pixel_result_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  mandel_pkg::cfg_index_e         cfg_index_i = mandel_pkg::CFG_EXT_RED;
  logic [mandel_pkg::CFG_W-1:0]   cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  logic [mandel_pkg::COORD_W-1:0] column_i    = '0;
  logic [mandel_pkg::COORD_W-1:0] row_i       = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [mandel_pkg::ITER_W-1:0]  iterations_o;
  logic                           inside_res_o;
  logic [mandel_pkg::COLOR_W-1:0] red_o;
  logic [mandel_pkg::COLOR_W-1:0] green_o;
  logic [mandel_pkg::COLOR_W-1:0] blue_o;

  // register copies
  logic [mandel_pkg::COLOR_W-1:0] ext_red    = mandel_pkg::EXT_COLOR_RST;
  logic [mandel_pkg::COLOR_W-1:0] ext_green  = mandel_pkg::EXT_COLOR_RST;
  logic [mandel_pkg::COLOR_W-1:0] ext_blue   = mandel_pkg::EXT_COLOR_RST;
  logic [mandel_pkg::ITER_W-1:0]  iter_limit = mandel_pkg::ITER_LIMIT_RST;

  pixel_t        pixel_q[$];
  pixel_result_t escape_q[$];
  pixel_t        next_pixel;
  pixel_result_t want;

  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 28;
  int unsigned hold_requests = 0;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned cycle_count   = 0;
  int unsigned errors        = 0;
  int unsigned pixels_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned inside_seen   = 0;
  int unsigned reg_writes    = 0;

  int unsigned phase_limit [NUM_PHASES] = '{1, 3, 8, 20, 50, 120, 255};
  int unsigned phase_items [NUM_PHASES] = '{150, 120, 150, 150, 150, 100, 80};

  mandelbrot_escape_time_pixel #(
    .IMAGE_SIZE    (IMAGE_SIZE),
    .FRACTION_BITS (FRACTION_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .column_i     (column_i),
    .row_i        (row_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .iterations_o (iterations_o),
    .inside_res_o (inside_res_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // floor of the fixed-point product, exact wide intermediate
  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    wa   = a;
    wb   = b;
    prod = (wa * wb) >>> FRACTION_BITS;
    return longint'(prod[63:0]);
  endfunction

  function automatic pixel_result_t escape_time(pixel_t px);
    pixel_result_t res;
    longint cx;
    longint cy;
    longint acy;
    longint zx;
    longint zy;
    longint zx2;
    longint zy2;
    int unsigned n;
    cx  = CX_ORIGIN + longint'(px.column) * PLANE_STEP;
    cy  = CY_ORIGIN + longint'(px.row) * PLANE_STEP;
    acy = (cy < 0) ? -cy : cy;
    if (acy * 2 < PLANE_STEP) cy = 0;
    zx  = 0;
    zy  = 0;
    zx2 = 0;
    zy2 = 0;
    n   = 0;
    while (n < iter_limit && zx2 + zy2 < ESCAPE_R2) begin
      zy  = fx_mul(zx * 2, zy) + cy;
      zx  = zx2 - zy2 + cx;
      zx2 = fx_mul(zx, zx);
      zy2 = fx_mul(zy, zy);
      n++;
    end
    res.iterations = n[mandel_pkg::ITER_W-1:0];
    res.in_set     = (n == iter_limit);
    res.red        = res.in_set ? '0 : ext_red;
    res.green      = res.in_set ? '0 : ext_green;
    res.blue       = res.in_set ? '0 : ext_blue;
    return res;
  endfunction

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      column_i   <= '0;
      row_i      <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        escape_q.insert(escape_q.size(),
                        escape_time(pixel_t'{column: column_i, row: row_i}));
        pixels_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pixel = pixel_q.pop_front();
          in_valid_i <= 1'b1;
          column_i   <= next_pixel.column;
          row_i      <= next_pixel.row;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (inside_res_o) inside_seen++;
        if (escape_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result transfer with nothing expected: iter %0d inside %0b",
                     $realtime, iterations_o, inside_res_o);
        end else begin
          want = escape_q.pop_front();
          if (iterations_o !== want.iterations || inside_res_o !== want.in_set ||
              red_o !== want.red || green_o !== want.green || blue_o !== want.blue) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] mismatch: exp iter %0d in %0b rgb %0d/%0d/%0d", $realtime,
                       want.iterations, want.in_set, want.red, want.green, want.blue);
              $display("         got iter %0d in %0b rgb %0d/%0d/%0d",
                       iterations_o, inside_res_o, red_o, green_o, blue_o);
            end
          end
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left   <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
        out_ready_i <= 1'b0;
        hold_left   <= HOLD_CYCLES;
        hold_served <= hold_requests;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               escape_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(mandel_pkg::cfg_index_e idx,
                           logic [mandel_pkg::CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    unique case (idx)
      mandel_pkg::CFG_EXT_RED:    ext_red    = value[mandel_pkg::COLOR_W-1:0];
      mandel_pkg::CFG_EXT_GREEN:  ext_green  = value[mandel_pkg::COLOR_W-1:0];
      mandel_pkg::CFG_EXT_BLUE:   ext_blue   = value[mandel_pkg::COLOR_W-1:0];
      mandel_pkg::CFG_ITER_LIMIT: iter_limit = value[mandel_pkg::ITER_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_colours(logic [mandel_pkg::COLOR_W-1:0] r,
                             logic [mandel_pkg::COLOR_W-1:0] g,
                             logic [mandel_pkg::COLOR_W-1:0] b);
    write_reg(mandel_pkg::CFG_EXT_RED, mandel_pkg::CFG_W'(r));
    write_reg(mandel_pkg::CFG_EXT_GREEN, mandel_pkg::CFG_W'(g));
    write_reg(mandel_pkg::CFG_EXT_BLUE, mandel_pkg::CFG_W'(b));
  endtask

  task automatic add_pixel(int unsigned col, int unsigned row);
    pixel_q.insert(pixel_q.size(), pixel_t'{column: col[mandel_pkg::COORD_W-1:0],
                                            row: row[mandel_pkg::COORD_W-1:0]});
  endtask

  // mostly on-image pixels, a share around the set, some anywhere in the field
  task automatic add_random_pixels(int unsigned count);
    int unsigned sel;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 55)
        add_pixel($urandom_range(IMAGE_SIZE - 1), $urandom_range(IMAGE_SIZE - 1));
      else if (sel < 85)
        add_pixel($urandom_range(600, 100), $urandom_range(650, 150));
      else
        add_pixel($urandom_range(4095), $urandom_range(4095));
    end
  endtask

  // wait until every queued pixel has been sent and answered
  task automatic drain();
    @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || escape_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: corners, off-image, alternating bits, axis snap, inside points
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel(IMAGE_SIZE - 1, IMAGE_SIZE - 1);
    add_pixel(IMAGE_SIZE, IMAGE_SIZE);
    add_pixel(12'h555, 12'hAAA);
    add_pixel(12'hAAA, 12'h555);
    add_pixel(2048, 1024);
    add_pixel(500, 400);
    add_pixel(500, 399);
    add_pixel(500, 401);
    add_pixel(300, 400);
    add_pixel(150, 400);
    drain();

    // zero limit: every pixel counts as inside
    write_reg(mandel_pkg::CFG_ITER_LIMIT, '0);
    @(negedge clk_i);
    add_pixel(500, 400);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    drain();

    // largest limit, colour extremes
    set_colours(8'h00, 8'hFF, 8'h5A);
    write_reg(mandel_pkg::CFG_ITER_LIMIT, 12'hFFF);
    @(negedge clk_i);
    add_pixel(500, 400);
    add_pixel(0, 0);
    add_pixel(700, 100);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0)
        set_colours(8'h00, 8'h00, 8'h00);
      else
        set_colours(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
      write_reg(mandel_pkg::CFG_ITER_LIMIT, mandel_pkg::CFG_W'(phase_limit[p]));
      @(negedge clk_i);
      send_idle_pct = (p == 2) ? 0 : 28;
      recv_idle_pct = (p == 2) ? 0 : 28;
      add_random_pixels(phase_items[p]);
      if (p == 0 || p == 4) hold_requests++;
      drain();
    end

    repeat (SETTLE_WAIT) @(negedge clk_i);

    $display("%0d pixels sent, %0d results checked, %0d of them inside the set",
             pixels_sent, results_seen, inside_seen);
    $display("%0d register writes across %0d limit settings, %0d errors",
             reg_writes, NUM_PHASES + 3, errors);
    if (errors == 0 && escape_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d results still expected", escape_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
